>>> rtl/core/fpd_pkg.sv
// flight phase detector shared types, constants and microcode table
`default_nettype none

package fpd_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 64;

   localparam int SAMPLE_W = 15;
   localparam int REG_W    = 19;
   localparam int SLOPE_W  = 20;
   localparam int PHASE_W  = 3;
   localparam int STEP_W   = 4;
   localparam int COND_W   = 3;
   localparam int INDEX_W  = 1;

   localparam logic [REG_W-1:0] LAUNCH_THRESHOLD_RESET = REG_W'(50);
   localparam logic [REG_W-1:0] STILL_TOLERANCE_RESET  = REG_W'(0);

   localparam logic [INDEX_W-1:0] REG_LAUNCH_THRESHOLD = 1'd0;
   localparam logic [INDEX_W-1:0] REG_STILL_TOLERANCE  = 1'd1;

   localparam logic [PHASE_W-1:0] PHASE_STANDBY  = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_ASCENT   = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_APOGEE   = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_DESCENT  = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_RECOVERY = 3'd4;

   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd0;
   localparam logic [COND_W-1:0] COND_NO_REQ   = 3'd1;
   localparam logic [COND_W-1:0] COND_PRIMED   = 3'd2;
   localparam logic [COND_W-1:0] COND_CNT_MORE = 3'd3;
   localparam logic [COND_W-1:0] COND_APOGEE   = 3'd4;
   localparam logic [COND_W-1:0] COND_HOLD     = 3'd5;
   localparam logic [COND_W-1:0] COND_RSP_BUSY = 3'd6;
   localparam logic [COND_W-1:0] COND_NEVER    = 3'd7;

   localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_PRIME    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_FILL     = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd3;
   localparam logic [STEP_W-1:0] STEP_HOLDCHK  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_SHIFT    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_EVAL     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_SCAN     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_DRAIN    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DECIDE   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_RESULT   = 4'd10;

   typedef struct packed {
      logic              accept;
      logic              cnt_clr;
      logic              fill;
      logic              shift;
      logic              scan;
      logic              eval;
      logic              result;
      logic              last;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } fpd_ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic primed;
      logic cnt_more;
      logic is_apogee;
      logic is_hold;
      logic rsp_busy;
   } fpd_status_type;

   function automatic fpd_ctrl_type fpd_ucode(input logic [STEP_W-1:0] step);
      fpd_ctrl_type w;
      w = '0;
      w.cond = COND_NEVER;
      unique case (step)
         STEP_WAIT: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = STEP_WAIT;
         end
         STEP_PRIME: begin
            w.cnt_clr = 1'b1;
            w.cond    = COND_PRIMED;
            w.target  = STEP_DISPATCH;
         end
         STEP_FILL: begin
            w.fill   = 1'b1;
            w.cond   = COND_CNT_MORE;
            w.target = STEP_FILL;
         end
         STEP_DISPATCH: begin
            w.cnt_clr = 1'b1;
            w.cond    = COND_APOGEE;
            w.target  = STEP_SCAN;
         end
         STEP_HOLDCHK: begin
            w.cond   = COND_HOLD;
            w.target = STEP_RESULT;
         end
         STEP_SHIFT: begin
            w.shift = 1'b1;
         end
         STEP_EVAL: begin
            w.eval   = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = STEP_RESULT;
         end
         STEP_SCAN: begin
            w.scan   = 1'b1;
            w.cond   = COND_CNT_MORE;
            w.target = STEP_SCAN;
         end
         STEP_DRAIN: begin
            w.cond = COND_NEVER;
         end
         STEP_DECIDE: begin
            w.eval  = 1'b1;
            w.shift = 1'b1;
         end
         STEP_RESULT: begin
            w.result = 1'b1;
            w.last   = 1'b1;
            w.cond   = COND_RSP_BUSY;
            w.target = STEP_RESULT;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/fpd_ram.sv
// generic single write port ram with registered read
`default_nettype none

module fpd_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/fpd_sequencer.sv
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none

module fpd_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fpd_pkg::fpd_status_type status,
   output fpd_pkg::fpd_ctrl_type       ctrl
);
   import fpd_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              taken;

   assign ctrl = fpd_ucode(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_ALWAYS:   taken = 1'b1;
         COND_NO_REQ:   taken = !status.req_valid;
         COND_PRIMED:   taken = status.primed;
         COND_CNT_MORE: taken = status.cnt_more;
         COND_APOGEE:   taken = status.is_apogee;
         COND_HOLD:     taken = status.is_hold;
         COND_RSP_BUSY: taken = status.rsp_busy;
         COND_NEVER:    taken = 1'b0;
         default:       taken = 1'b0;
      endcase
   end

   always_comb begin
      priority if (taken) begin
         step_in = ctrl.target;
      end else if (ctrl.last) begin
         step_in = STEP_WAIT;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/fpd_datapath.sv
// datapath: sample window, slope taps, apogee scan, phase and result registers
`default_nettype none

module fpd_datapath #(
   parameter int WINDOW_DEPTH = fpd_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fpd_pkg::fpd_ctrl_type         ctrl,
   output fpd_pkg::fpd_status_type            status,
   input  wire logic                          req_valid,
   input  wire logic [fpd_pkg::SAMPLE_W-1:0]  req_altitude_sample,
   input  wire logic [fpd_pkg::REG_W-1:0]     launch_threshold,
   input  wire logic [fpd_pkg::REG_W-1:0]     still_tolerance,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [fpd_pkg::PHASE_W-1:0]        rsp_phase,
   output logic [fpd_pkg::SAMPLE_W-1:0]       rsp_apogee_value,
   output logic signed [fpd_pkg::SLOPE_W-1:0] rsp_slope_numerator,
   output logic                               rsp_phase_changed
);
   import fpd_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

   logic [SAMPLE_W-1:0] sample_ff;
   logic [PHASE_W-1:0]  old_phase_ff;
   logic [PHASE_W-1:0]  phase_ff;
   logic [PHASE_W-1:0]  phase_in;
   logic [SAMPLE_W-1:0] apogee_ff;
   logic                primed_ff;
   logic [AW-1:0]       cnt_ff;
   logic [AW-1:0]       ptr_ff;
   logic                rd_valid_ff;
   logic [SAMPLE_W-1:0] tap_ff [5];
   logic [SAMPLE_W-1:0] rd_data;
   logic                accept;
   logic                rsp_busy;
   logic                rsp_load;

   logic                rsp_valid_ff;
   logic [PHASE_W-1:0]  rsp_phase_ff;
   logic [SAMPLE_W-1:0] rsp_apogee_ff;
   logic [SLOPE_W-1:0]  rsp_slope_ff;
   logic                rsp_changed_ff;

   logic signed [SLOPE_W-1:0] d_outer;
   logic signed [SLOPE_W-1:0] d_inner;
   logic signed [SLOPE_W-1:0] slope;
   logic        [SLOPE_W-1:0] slope_mag;

   assign accept   = ctrl.accept && req_valid;
   assign rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_load = ctrl.result && !rsp_busy;

   assign status.req_valid = req_valid;
   assign status.primed    = primed_ff;
   assign status.cnt_more  = (cnt_ff != LAST_ADDR);
   assign status.is_apogee = (phase_ff == PHASE_APOGEE);
   assign status.is_hold   = (phase_ff != PHASE_STANDBY) && (phase_ff != PHASE_ASCENT) &&
                             (phase_ff != PHASE_APOGEE) && (phase_ff != PHASE_DESCENT);
   assign status.rsp_busy  = rsp_busy;

   fpd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ctrl.fill || ctrl.shift),
      .wr_addr (ctrl.fill ? cnt_ff : ptr_ff),
      .wr_data (sample_ff),
      .rd_en   (ctrl.scan),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   // slope numerator 10*(y5-y1) + 5*(y4-y2)
   assign d_outer   = $signed({{(SLOPE_W-SAMPLE_W){1'b0}}, tap_ff[4]}) -
                      $signed({{(SLOPE_W-SAMPLE_W){1'b0}}, tap_ff[0]});
   assign d_inner   = $signed({{(SLOPE_W-SAMPLE_W){1'b0}}, tap_ff[3]}) -
                      $signed({{(SLOPE_W-SAMPLE_W){1'b0}}, tap_ff[1]});
   assign slope     = (d_outer <<< 3) + (d_outer <<< 1) + (d_inner <<< 2) + d_inner;
   assign slope_mag = slope[SLOPE_W-1] ? SLOPE_W'(-slope) : SLOPE_W'(slope);

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PHASE_STANDBY: begin
            if (slope > $signed({1'b0, launch_threshold})) begin
               phase_in = PHASE_ASCENT;
            end
         end
         PHASE_ASCENT: begin
            if (slope[SLOPE_W-1]) begin
               phase_in = PHASE_APOGEE;
            end
         end
         PHASE_APOGEE: begin
            if (tap_ff[4] < apogee_ff) begin
               phase_in = PHASE_DESCENT;
            end
         end
         PHASE_DESCENT: begin
            if (slope_mag <= {1'b0, still_tolerance}) begin
               phase_in = PHASE_RECOVERY;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff    <= req_altitude_sample;
         old_phase_ff <= phase_ff;
      end
      if (ctrl.fill) begin
         for (int i = 0; i < 5; i++) begin
            tap_ff[i] <= sample_ff;
         end
      end else if (ctrl.shift) begin
         for (int i = 0; i < 4; i++) begin
            tap_ff[i] <= tap_ff[i+1];
         end
         tap_ff[4] <= sample_ff;
      end
      if (rsp_load) begin
         rsp_phase_ff   <= phase_ff;
         rsp_apogee_ff  <= apogee_ff;
         rsp_slope_ff   <= slope;
         rsp_changed_ff <= (phase_ff != old_phase_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_STANDBY;
         apogee_ff    <= '0;
         primed_ff    <= 1'b0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctrl.scan;
         if (ctrl.fill) begin
            primed_ff <= 1'b1;
         end
         if (ctrl.cnt_clr) begin
            cnt_ff <= '0;
         end else if (ctrl.fill || ctrl.scan) begin
            cnt_ff <= AW'(cnt_ff + AW'(1));
         end
         if (ctrl.shift) begin
            ptr_ff <= (ptr_ff == LAST_ADDR) ? '0 : AW'(ptr_ff + AW'(1));
         end
         if (rd_valid_ff && (rd_data > apogee_ff)) begin
            apogee_ff <= rd_data;
         end
         if (ctrl.eval) begin
            phase_ff <= phase_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_phase           = rsp_phase_ff;
   assign rsp_apogee_value    = rsp_apogee_ff;
   assign rsp_slope_numerator = rsp_slope_ff;
   assign rsp_phase_changed   = rsp_changed_ff;

`ifndef SYNTHESIS
   a_phase_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (phase_ff != $past(phase_ff))) |->
      (phase_ff == $past(phase_ff) + 3'd1))
      else $error("phase skipped or went back");

   a_apogee_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (apogee_ff >= $past(apogee_ff)))
      else $error("apogee value decreased");

   a_primed_before_launch: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PHASE_STANDBY) |-> primed_ff)
      else $error("phase left standby with an unfilled window");
`endif

endmodule

`default_nettype wire

>>> rtl/core/flight_phase_detector_core.sv
// flight phase detector top level: configuration registers, sequencer and datapath
//
// channel  direction  handshake          payload
// req      in         req_valid/ready    req_altitude_sample
// rsp      out        rsp_valid/ready    rsp_phase, rsp_apogee_value,
//                                        rsp_slope_numerator, rsp_phase_changed
// csr      in         csr_valid/ready    csr_index, csr_data
//
// one item at a time; standby, ascent and descent shift the window and evaluate the slope
// apogee scans the whole window ram through its one read port before the result
// the first item after reset first writes every window entry
// a held result stalls the sequencer in its result step; csr writes are taken outside reset
// reset is synchronous and clears the phase, apogee value and window fill flag
`default_nettype none

module flight_phase_detector_core #(
   parameter int WINDOW_DEPTH = fpd_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [fpd_pkg::SAMPLE_W-1:0]  req_altitude_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [fpd_pkg::PHASE_W-1:0]        rsp_phase,
   output logic [fpd_pkg::SAMPLE_W-1:0]       rsp_apogee_value,
   output logic signed [fpd_pkg::SLOPE_W-1:0] rsp_slope_numerator,
   output logic                               rsp_phase_changed,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fpd_pkg::INDEX_W-1:0]   csr_index,
   input  wire logic [fpd_pkg::REG_W-1:0]     csr_data
);
   import fpd_pkg::*;

   fpd_ctrl_type   ctrl;
   fpd_status_type status;

   logic [REG_W-1:0] launch_threshold_ff;
   logic [REG_W-1:0] still_tolerance_ff;

   assign csr_ready = !reset;
   assign req_ready = ctrl.accept && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_threshold_ff <= LAUNCH_THRESHOLD_RESET;
         still_tolerance_ff  <= STILL_TOLERANCE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_LAUNCH_THRESHOLD: launch_threshold_ff <= csr_data;
            REG_STILL_TOLERANCE:  still_tolerance_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   fpd_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   fpd_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .status              (status),
      .req_valid           (req_valid),
      .req_altitude_sample (req_altitude_sample),
      .launch_threshold    (launch_threshold_ff),
      .still_tolerance     (still_tolerance_ff),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_phase           (rsp_phase),
      .rsp_apogee_value    (rsp_apogee_value),
      .rsp_slope_numerator (rsp_slope_numerator),
      .rsp_phase_changed   (rsp_phase_changed)
   );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench for flight_phase_detector_core: phase predictor, handshake drivers and result checks
`timescale 1ns / 100ps

module tb;
   import fpd_pkg::*;

   localparam int DEPTH        = WINDOW_DEPTH_DEFAULT;
   localparam int FIT_POINTS   = 5;
   localparam int SUM_X        = 15;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
   localparam int LEVEL_MAX    = 491505;
   localparam int HOLD_STRETCH = 200;
   localparam int STALL_LIMIT  = 3000;

   typedef struct packed {
      logic [PHASE_W-1:0]        phase;
      logic [SAMPLE_W-1:0]       apogee;
      logic signed [SLOPE_W-1:0] slope;
      logic                      changed;
   } flight_report_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [SAMPLE_W-1:0]         req_altitude_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [PHASE_W-1:0]          rsp_phase;
   logic [SAMPLE_W-1:0]         rsp_apogee_value;
   logic signed [SLOPE_W-1:0]   rsp_slope_numerator;
   logic                        rsp_phase_changed;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [INDEX_W-1:0]          csr_index = '0;
   logic [REG_W-1:0]            csr_data = '0;

   // predictor state
   logic [SAMPLE_W-1:0] window_img [DEPTH];
   logic                window_filled = 1'b0;
   logic [PHASE_W-1:0]  flight_state = PHASE_STANDBY;
   logic [SAMPLE_W-1:0] apogee_img = '0;
   logic [REG_W-1:0]    launch_level = LAUNCH_THRESHOLD_RESET;
   logic [REG_W-1:0]    still_level = STILL_TOLERANCE_RESET;

   flight_report_type pending_reports [$];
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   int             hold_off_cycles = 0;
   int             rsp_idle = 0;
   bit             no_idle = 1'b0;

   flight_phase_detector_core DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_altitude_sample (req_altitude_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_phase           (rsp_phase),
      .rsp_apogee_value    (rsp_apogee_value),
      .rsp_slope_numerator (rsp_slope_numerator),
      .rsp_phase_changed   (rsp_phase_changed),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // least-squares numerator over the newest five entries, x = 1..5
   function automatic int fit_numerator();
      int acc;
      acc = 0;
      for (int k = 0; k < FIT_POINTS; k++)
         acc += (FIT_POINTS * (k + 1) - SUM_X) * int'(window_img[DEPTH-FIT_POINTS+k]);
      return acc;
   endfunction

   // numerator the window would give once s is shifted in
   function automatic int numerator_after(input logic [SAMPLE_W-1:0] s);
      int acc;
      acc = (FIT_POINTS * FIT_POINTS - SUM_X) * int'(s);
      for (int k = 0; k < FIT_POINTS - 1; k++)
         acc += (FIT_POINTS * (k + 1) - SUM_X) * int'(window_img[DEPTH-FIT_POINTS+1+k]);
      return acc;
   endfunction

   function automatic void shift_window(input logic [SAMPLE_W-1:0] s);
      for (int k = 0; k < DEPTH - 1; k++)
         window_img[k] = window_img[k+1];
      window_img[DEPTH-1] = s;
   endfunction

   function automatic flight_report_type advance_flight(input logic [SAMPLE_W-1:0] s);
      flight_report_type  r;
      logic [PHASE_W-1:0] prior;
      prior = flight_state;
      if (!window_filled) begin
         for (int k = 0; k < DEPTH; k++)
            window_img[k] = s;
         window_filled = 1'b1;
      end
      case (flight_state)
         PHASE_STANDBY: begin
            shift_window(s);
            if (fit_numerator() > int'(launch_level))
               flight_state = PHASE_ASCENT;
         end
         PHASE_ASCENT: begin
            shift_window(s);
            if (fit_numerator() < 0)
               flight_state = PHASE_APOGEE;
         end
         PHASE_APOGEE: begin
            for (int k = 0; k < DEPTH; k++)
               if (window_img[k] > apogee_img)
                  apogee_img = window_img[k];
            if (window_img[DEPTH-1] < apogee_img)
               flight_state = PHASE_DESCENT;
            shift_window(s);
         end
         PHASE_DESCENT: begin
            shift_window(s);
            if (magnitude(fit_numerator()) <= int'(still_level))
               flight_state = PHASE_RECOVERY;
         end
         default: begin
         end
      endcase
      r.phase   = flight_state;
      r.apogee  = apogee_img;
      r.slope   = SLOPE_W'(fit_numerator());
      r.changed = (flight_state != prior);
      return r;
   endfunction

   function automatic int drift(input int base, input int span);
      int v;
      v = base + int'($urandom_range(2 * span)) - span;
      if (v < 0)
         v = 0;
      if (v > SAMPLE_MAX)
         v = SAMPLE_MAX;
      return v;
   endfunction

   task automatic send_altitude(input logic [SAMPLE_W-1:0] s);
      int gap;
      gap = no_idle ? 0 : $urandom_range(3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_altitude_sample <= s;
      do @(posedge clock); while (!req_ready);
      pending_reports.push_back(advance_flight(s));
      if ($urandom_range(31) == 0)
         no_idle = !no_idle;
   endtask

   task automatic await_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   task automatic write_register(input logic [INDEX_W-1:0] idx, input int value);
      await_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= REG_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_LAUNCH_THRESHOLD)
         launch_level = REG_W'(value);
      else
         still_level = REG_W'(value);
   endtask

   task automatic check_field(input string label, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // result side: random idle per transfer, long hold-off on request
   always @(posedge clock) begin : responder
      int draw_cycles;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_idle  <= 0;
      end else if (hold_off_cycles != 0) begin
         hold_off_cycles = hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_ready && rsp_valid) begin
         draw_cycles = no_idle ? 0 : $urandom_range(3);
         rsp_ready <= (draw_cycles == 0);
         rsp_idle  <= draw_cycles;
      end else if (!rsp_ready) begin
         if (rsp_idle <= 1)
            rsp_ready <= 1'b1;
         else
            rsp_idle <= rsp_idle - 1;
      end
   end

   always @(posedge clock) begin : report_check
      flight_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: phase expected no result got %0d", $time, rsp_phase);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("phase", want.phase, rsp_phase);
            check_field("apogee_value", want.apogee, rsp_apogee_value);
            check_field("slope_numerator", $signed(want.slope), rsp_slope_numerator);
            check_field("phase_changed", want.changed, rsp_phase_changed);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // first sample primes the window, reset threshold edge, numerator extremes
   task automatic test_reset_levels_and_extremes();
      int extremes [10];
      extremes = '{0, 0, 0, 0, SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0, SAMPLE_MAX};
      send_altitude(0);
      send_altitude(5);
      send_altitude(0);
      write_register(REG_LAUNCH_THRESHOLD, LEVEL_MAX);
      foreach (extremes[i])
         send_altitude(SAMPLE_W'(extremes[i]));
   endtask

   task automatic test_standby_noise();
      int last;
      last = $urandom_range(SAMPLE_MAX);
      for (int i = 0; i < 360; i++) begin
         if (i == 150)
            hold_off_cycles = HOLD_STRETCH;
         if (i % 64 < 32)
            last = $urandom_range(SAMPLE_MAX);
         else
            last = drift(last, 300);
         send_altitude(SAMPLE_W'(last));
      end
      await_idle();
   endtask

   // threshold set to exactly the coming numerator: no launch
   task automatic test_launch_edge();
      int s;
      int n;
      for (int i = 0; i < 8; i++) begin
         s = $urandom_range(SAMPLE_MAX);
         n = numerator_after(SAMPLE_W'(s));
         write_register(REG_LAUNCH_THRESHOLD, (n < 0) ? 0 : n);
         send_altitude(SAMPLE_W'(s));
      end
   endtask

   task automatic test_launch(output int level);
      level = $urandom_range(1000, 4000);
      write_register(REG_LAUNCH_THRESHOLD, LEVEL_MAX);
      repeat (5) send_altitude(SAMPLE_W'(level));
      write_register(REG_LAUNCH_THRESHOLD, 0);
      send_altitude(SAMPLE_W'(level));
      level = level + $urandom_range(1, 20);
      send_altitude(SAMPLE_W'(level));
   endtask

   task automatic test_ascent(inout int level);
      write_register(REG_LAUNCH_THRESHOLD, LAUNCH_THRESHOLD_RESET);
      for (int i = 0; i < 150; i++) begin
         if ($urandom_range(3) != 0)
            level = level + $urandom_range(1, 60);
         send_altitude(SAMPLE_W'(level));
      end
   endtask

   // slope turns negative with the newest sample at the window maximum
   task automatic test_apogee_entry(inout int level);
      level = level + 10;
      repeat (3) send_altitude(SAMPLE_W'(level));
      send_altitude(SAMPLE_W'(level - 1));
      send_altitude(SAMPLE_W'(level));
   endtask

   task automatic test_apogee_tracking(inout int level);
      write_register(REG_STILL_TOLERANCE, 0);
      for (int i = 0; i < 100; i++) begin
         if (i == 40)
            hold_off_cycles = HOLD_STRETCH;
         if (i < 80)
            level = level + $urandom_range(300);
         else
            level = SAMPLE_MAX;
         if (level > SAMPLE_MAX)
            level = SAMPLE_MAX;
         send_altitude(SAMPLE_W'(level));
      end
      send_altitude(SAMPLE_W'($urandom_range(SAMPLE_MAX - 1)));
   endtask

   task automatic test_descent();
      int levels [3];
      int s;
      int n;
      int tries;
      levels = '{0, $urandom_range(1, 2000), $urandom_range(20000, 150000)};
      foreach (levels[j]) begin
         write_register(REG_STILL_TOLERANCE, levels[j]);
         for (int i = 0; i < 80; i++) begin
            tries = 0;
            do begin
               if ($urandom_range(1) == 0)
                  s = $urandom_range(SAMPLE_MAX);
               else
                  s = drift(int'(window_img[DEPTH-1]), 2000);
               tries++;
            end while (magnitude(numerator_after(SAMPLE_W'(s))) <= int'(still_level) &&
                       tries < 50);
            send_altitude(SAMPLE_W'(s));
         end
      end
      // tolerance just under the coming magnitude: descent holds
      for (int i = 0; i < 5; i++) begin
         s = $urandom_range(SAMPLE_MAX);
         n = magnitude(numerator_after(SAMPLE_W'(s)));
         if (n > 0) begin
            write_register(REG_STILL_TOLERANCE, n - 1);
            send_altitude(SAMPLE_W'(s));
         end
      end
      s = $urandom_range(SAMPLE_MAX);
      write_register(REG_STILL_TOLERANCE, magnitude(numerator_after(SAMPLE_W'(s))));
      send_altitude(SAMPLE_W'(s));
   endtask

   // recovery holds everything whatever the registers say
   task automatic test_recovery_hold();
      write_register(REG_LAUNCH_THRESHOLD, $urandom_range(LEVEL_MAX));
      write_register(REG_STILL_TOLERANCE, LEVEL_MAX);
      for (int i = 0; i < 30; i++)
         send_altitude(SAMPLE_W'($urandom_range(SAMPLE_MAX)));
      hold_off_cycles = HOLD_STRETCH;
      write_register(REG_LAUNCH_THRESHOLD, 0);
      write_register(REG_STILL_TOLERANCE, $urandom_range(LEVEL_MAX));
      for (int i = 0; i < 30; i++)
         send_altitude(SAMPLE_W'($urandom_range(SAMPLE_MAX)));
   endtask

   initial begin
      int level;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_levels_and_extremes();
      test_standby_noise();
      test_launch_edge();
      test_launch(level);
      test_ascent(level);
      test_apogee_entry(level);
      test_apogee_tracking(level);
      test_descent();
      test_recovery_hold();
      await_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/fpd_pkg.sv
rtl/core/fpd_ram.sv
rtl/core/fpd_sequencer.sv
rtl/core/fpd_datapath.sv
rtl/core/flight_phase_detector_core.sv
tb/sv/tb.sv
